>>> rtl/core/lkv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_pkg
// shared constants, types and codes of the lru key-value cache
// ----------------------------------------------------------------------------
package lkv_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int KEY_W   = 16;
	localparam int VAL_W   = 32;
	localparam int CAP_W   = 5;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	localparam logic [ADDR_W-3:0] REG_CAPACITY = '0;
	localparam logic [CAP_W-1:0]  CAP_RESET    = CAP_W'(16);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_ADJUST
	} state_t;

	typedef struct packed {
		logic load;
		logic touch;
		logic drop_hit;
		logic evict;
		logic insert;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic hit;
		logic op;
		logic full;
		logic out_busy;
	} status_t;

endpackage

>>> rtl/core/lkv_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_req_if
// request channel: opcode, key and value with valid/ready
// ----------------------------------------------------------------------------
interface lkv_req_if import lkv_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    opcode;
	logic [KEY_W-1:0]        lookup_key;
	logic signed [VAL_W-1:0] write_value;

	modport source (output valid, output opcode, output lookup_key, output write_value,
		input ready);
	modport sink (input valid, input opcode, input lookup_key, input write_value,
		output ready);
endinterface

>>> rtl/core/lkv_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_rsp_if
// response channel: found flag and value with valid/ready
// ----------------------------------------------------------------------------
interface lkv_rsp_if import lkv_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    found;
	logic signed [VAL_W-1:0] read_value;

	modport source (output valid, output found, output read_value, input ready);
	modport sink (input valid, input found, input read_value, output ready);
endinterface

>>> rtl/core/lkv_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_regs
// apb register block holding the capacity setting
// ----------------------------------------------------------------------------
module lkv_regs import lkv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output logic [CNT_W-1:0]  cap_eff
);

	logic [CAP_W-1:0] cap_q;
	logic             cap_sel;

	assign cap_sel = (paddr[ADDR_W-1:2] == REG_CAPACITY);
	assign pready  = 1'b1;
	assign prdata  = cap_sel ? DATA_W'(cap_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && cap_sel) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	// zero means one, above the store size saturates
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CNT_W'(1);
		end else if (int'(cap_q) > ENTRIES) begin
			cap_eff = CNT_W'(ENTRIES);
		end else begin
			cap_eff = CNT_W'(cap_q);
		end
	end

endmodule

>>> rtl/core/lkv_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_dp
// datapath: entry store, recency ranks, key match and response register
// ----------------------------------------------------------------------------
module lkv_dp import lkv_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cmd_t                    cmd,
	input  logic                    in_opcode,
	input  logic [KEY_W-1:0]        in_key,
	input  logic signed [VAL_W-1:0] in_value,
	input  logic [CNT_W-1:0]        cap_eff,
	input  logic                    rsp_ready,
	output status_t                 status,
	output logic                    rsp_valid,
	output logic                    rsp_found,
	output logic signed [VAL_W-1:0] rsp_value
);

	logic [KEY_W-1:0]        key_mem_q   [ENTRIES];
	logic signed [VAL_W-1:0] value_mem_q [ENTRIES];
	logic [IDX_W-1:0]        rank_q      [ENTRIES];
	logic [ENTRIES-1:0]      valid_q;
	logic [CNT_W-1:0]        count_q;

	logic                    op_q;
	logic [KEY_W-1:0]        key_q;
	logic signed [VAL_W-1:0] value_q;

	logic                    out_valid_q;
	logic                    out_found_q;
	logic signed [VAL_W-1:0] out_value_q;

	logic [ENTRIES-1:0] hit_vec;
	logic [IDX_W-1:0]   hit_idx;
	logic [IDX_W-1:0]   free_idx;
	logic [IDX_W-1:0]   victim_idx;
	logic [IDX_W-1:0]   victim_rank;
	logic [IDX_W-1:0]   hit_rank;
	logic               hit;

	// key match and slot selection
	assign victim_rank = IDX_W'(count_q - CNT_W'(1));

	always_comb begin
		hit_idx    = '0;
		free_idx   = '0;
		victim_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			hit_vec[i] = valid_q[i] && (key_mem_q[i] == key_q);
			if (hit_vec[i]) begin
				hit_idx = IDX_W'(i);
			end
			if (!valid_q[i]) begin
				free_idx = IDX_W'(i);
			end
			if (valid_q[i] && rank_q[i] == victim_rank) begin
				victim_idx = IDX_W'(i);
			end
		end
	end

	assign hit      = |hit_vec;
	assign hit_rank = rank_q[hit_idx];

	assign status.hit      = hit;
	assign status.op       = op_q;
	assign status.full     = (count_q >= cap_eff);
	assign status.out_busy = out_valid_q && !rsp_ready;

	// current item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= in_opcode;
			key_q   <= in_key;
			value_q <= in_value;
		end
	end

	// entry payload
	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			key_mem_q[free_idx]   <= key_q;
			value_mem_q[free_idx] <= value_q;
		end
	end

	// valid marks, ranks and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			for (int j = 0; j < ENTRIES; j++) begin
				rank_q[j] <= '0;
			end
		end else if (cmd.touch) begin
			for (int j = 0; j < ENTRIES; j++) begin
				if (valid_q[j] && rank_q[j] < hit_rank) begin
					rank_q[j] <= rank_q[j] + IDX_W'(1);
				end
			end
			rank_q[hit_idx] <= '0;
		end else if (cmd.drop_hit) begin
			for (int j = 0; j < ENTRIES; j++) begin
				if (valid_q[j] && rank_q[j] > hit_rank) begin
					rank_q[j] <= rank_q[j] - IDX_W'(1);
				end
			end
			valid_q[hit_idx] <= 1'b0;
			rank_q[hit_idx]  <= '0;
			count_q          <= count_q - CNT_W'(1);
		end else if (cmd.evict) begin
			// victim holds the highest rank, nothing above it to shift
			valid_q[victim_idx] <= 1'b0;
			rank_q[victim_idx]  <= '0;
			count_q             <= count_q - CNT_W'(1);
		end else if (cmd.insert) begin
			for (int j = 0; j < ENTRIES; j++) begin
				if (valid_q[j]) begin
					rank_q[j] <= rank_q[j] + IDX_W'(1);
				end
			end
			valid_q[free_idx] <= 1'b1;
			rank_q[free_idx]  <= '0;
			count_q           <= count_q + CNT_W'(1);
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_found_q <= hit;
			out_value_q <= hit ? value_mem_q[hit_idx] : '0;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_found = out_found_q;
	assign rsp_value = out_value_q;

	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CNT_W'($countones(valid_q)))
		else $error("fill count differs from number of valid entries");

	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec))
		else $error("key present in more than one entry");

	a_insert_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |-> !(&valid_q))
		else $error("insert with no free entry");

	a_evict_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.evict |-> (count_q != '0))
		else $error("evict from an empty store");

	a_response_held: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !status.out_busy)
		else $error("response overwritten before it was taken");

endmodule

>>> rtl/core/lkv_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_ctrl
// sequencer: accept, search, then evict and insert for puts
// ----------------------------------------------------------------------------
module lkv_ctrl import lkv_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	input  status_t status,
	output logic    req_ready,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_next = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (status.op == OP_PUT) begin
					state_next = ST_ADJUST;
				end else if (!status.out_busy) begin
					state_next = ST_IDLE;
				end
			end
			ST_ADJUST: begin
				if (!status.full) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			ST_SEARCH: begin
				if (status.op == OP_PUT) begin
					cmd.drop_hit = status.hit;
				end else if (!status.out_busy) begin
					cmd.out_load = 1'b1;
					cmd.touch    = status.hit;
				end
			end
			ST_ADJUST: begin
				if (status.full) begin
					cmd.evict = 1'b1;
				end else begin
					cmd.insert = 1'b1;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

>>> rtl/core/lru_key_value_cache_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_top
// fully associative key-value cache with least recently used replacement
// ----------------------------------------------------------------------------
// A get is accepted, then a parallel key match over all entries loads
// the response register and updates ranks; the match stalls while an
// earlier response still waits untaken in that register. A put is
// accepted, then matched with drop of an old copy, then inserted; before
// the insert, entries are evicted to get under the capacity, normally at
// most one, up to the fill count after the capacity was lowered. The
// sequencer in lkv_ctrl handles one item at a time; a finished response
// waits in its own register, so a new item is taken while it is pending.
// Valid marks are cleared at reset, so no clearing pass is needed. The
// capacity register sits at byte address 0; zero acts as one and values
// above the entry count saturate.
module lru_key_value_cache_top import lkv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	lkv_req_if.sink           req,
	lkv_rsp_if.source         rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	cmd_t             cmd;
	status_t          status;
	logic [CNT_W-1:0] cap_eff;

	lkv_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cap_eff (cap_eff)
	);

	lkv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.status    (status),
		.req_ready (req.ready),
		.cmd       (cmd)
	);

	lkv_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_opcode (req.opcode),
		.in_key    (req.lookup_key),
		.in_value  (req.write_value),
		.cap_eff   (cap_eff),
		.rsp_ready (rsp.ready),
		.status    (status),
		.rsp_valid (rsp.valid),
		.rsp_found (rsp.found),
		.rsp_value (rsp.read_value)
	);

endmodule
